// ----- hdl/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and fixed widths for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

	localparam int WORD_W     = 32;
	localparam int VEC_W      = 64;
	localparam int POS_W      = 6;
	localparam int MAG_W      = 30;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = 31;
	localparam int SQRT_STEPS = 31;
	localparam int SQRT_RW    = SUM_W + 2;
	localparam int COL_W      = 2;

	localparam logic [COL_W-1:0] FIRST_COL = 2'd0;
	localparam logic [COL_W-1:0] LAST_COL  = 2'd3;

	typedef struct packed {
		logic signed [WORD_W-1:0] eye_x;
		logic signed [WORD_W-1:0] eye_y;
		logic signed [WORD_W-1:0] eye_z;
		logic signed [WORD_W-1:0] aim_x;
		logic signed [WORD_W-1:0] aim_y;
		logic signed [WORD_W-1:0] aim_z;
		logic signed [WORD_W-1:0] upward_x;
		logic signed [WORD_W-1:0] upward_y;
		logic signed [WORD_W-1:0] upward_z;
	} lav_cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]         column_index;
		logic signed [WORD_W-1:0] elem0;
		logic signed [WORD_W-1:0] elem1;
		logic signed [WORD_W-1:0] elem2;
		logic signed [WORD_W-1:0] elem3;
		logic                     degenerate;
		logic                     last_column;
	} lav_res_t;

endpackage

// ----- hdl/lav_sqrt.sv -----
// ----------------------------------------------------------------------------
// lav_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lav_sqrt #(
	parameter int PW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [lav_pkg::SUM_W-1:0]   in_sum,
	input  logic [PW-1:0]               in_pass,
	output logic                        out_valid,
	output logic [lav_pkg::ROOT_W-1:0]  out_root,
	output logic [PW-1:0]               out_pass
);
	import lav_pkg::*;

	logic [SQRT_STEPS:0] vld_s;
	logic [SQRT_RW-1:0]  x_s    [SQRT_STEPS+1];
	logic [SQRT_RW-1:0]  res_s  [SQRT_STEPS+1];
	logic [PW-1:0]       pass_s [SQRT_STEPS+1];

	assign vld_s[0]  = in_valid;
	assign x_s[0]    = SQRT_RW'(in_sum);
	assign res_s[0]  = '0;
	assign pass_s[0] = in_pass;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam int SH = 2 * (SQRT_STEPS - 1 - i);
		logic [SQRT_RW-1:0] bitv;
		logic [SQRT_RW-1:0] trial;
		assign bitv  = SQRT_RW'(1) << SH;
		assign trial = res_s[i] + bitv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			pass_s[i+1] <= pass_s[i];
			if (x_s[i] >= trial) begin
				x_s[i+1]   <= x_s[i] - trial;
				res_s[i+1] <= (res_s[i] >> 1) + bitv;
			end else begin
				x_s[i+1]   <= x_s[i];
				res_s[i+1] <= res_s[i] >> 1;
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign out_root  = res_s[SQRT_STEPS][ROOT_W-1:0];
	assign out_pass  = pass_s[SQRT_STEPS];

endmodule

// ----- hdl/lav_div.sv -----
// ----------------------------------------------------------------------------
// lav_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_div #(
	parameter int FRAC_BITS = 16,
	parameter int PW        = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [lav_pkg::ROOT_W-1:0]          in_den,
	input  logic [2:0][lav_pkg::MAG_W-1:0]      in_mag,
	input  logic [PW-1:0]                       in_pass,
	output logic                                out_valid,
	output logic [2:0][FRAC_BITS:0]             out_quo,
	output logic [PW-1:0]                       out_pass
);
	import lav_pkg::*;

	localparam int STAGES = FRAC_BITS + 1;
	localparam int QW     = FRAC_BITS + 1;

	logic [STAGES:0]           vld_s;
	logic [ROOT_W-1:0]         den_s  [STAGES+1];
	logic [2:0][ROOT_W-1:0]    rem_s  [STAGES+1];
	logic [2:0][QW-1:0]        quo_s  [STAGES+1];
	logic [PW-1:0]             pass_s [STAGES+1];

	assign vld_s[0]  = in_valid;
	assign den_s[0]  = in_den;
	assign pass_s[0] = in_pass;
	for (genvar l = 0; l < 3; l++) begin : g_init
		assign rem_s[0][l] = ROOT_W'(in_mag[l]);
		assign quo_s[0][l] = '0;
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [ROOT_W:0] t;
			logic            take;
			if (i == 0) begin : g_first
				assign t = {1'b0, rem_s[i][l]};
			end else begin : g_next
				assign t = {rem_s[i][l], 1'b0};
			end
			assign take = t >= {1'b0, den_s[i]};

			always_ff @(posedge clk) begin
				if (take) begin
					rem_s[i+1][l] <= ROOT_W'(t - {1'b0, den_s[i]});
				end else begin
					rem_s[i+1][l] <= t[ROOT_W-1:0];
				end
				quo_s[i+1][l] <= {quo_s[i][l][QW-2:0], take};
			end
		end

		always_ff @(posedge clk) begin
			den_s[i+1]  <= den_s[i];
			pass_s[i+1] <= pass_s[i];
		end
	end

	assign out_valid = vld_s[STAGES];
	assign out_quo   = quo_s[STAGES];
	assign out_pass  = pass_s[STAGES];

endmodule

// ----- hdl/lav_norm.sv -----
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalization: range shift, sum of squares, root, divide.
// ----------------------------------------------------------------------------
module lav_norm #(
	parameter int FRAC_BITS = 16,
	parameter int SW        = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ok,
	input  logic [2:0][lav_pkg::VEC_W-1:0]     in_vec,
	input  logic [SW-1:0]                      in_side,
	output logic                               out_valid,
	output logic                               out_ok,
	output logic [2:0][FRAC_BITS+1:0]          out_unit,
	output logic [SW-1:0]                      out_side
);
	import lav_pkg::*;

	localparam int UW   = FRAC_BITS + 2;
	localparam int QW   = FRAC_BITS + 1;
	localparam int SQPW = SW + 1 + 3 + 3 * MAG_W;
	localparam int DVPW = SW + 1 + 3;
	localparam logic [POS_W-1:0] TOP_POS = POS_W'(MAG_W - 1);

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic                   ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6, ok_s7;
	logic [SW-1:0]          side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [2:0]             neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [2:0][VEC_W-1:0]  mag_s1, mag_s2, mag_s3;
	logic [VEC_W-1:0]       max_s2, max_s3;
	logic [POS_W-1:0]       pos_s3;
	logic [2:0][MAG_W-1:0]  nm_s4, nm_s5, nm_s6;
	logic [2:0][SQ_W-1:0]   sq_s5;
	logic [SUM_W-1:0]       sum_s6;

	logic [POS_W-1:0]       pos_c;
	logic [2:0][MAG_W-1:0]  nm_c;
	logic [VEC_W-1:0]       mx01;

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < VEC_W; b++) begin
			if (max_s2[b]) pos_c = POS_W'(b);
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (pos_s3 > TOP_POS) begin
				nm_c[l] = MAG_W'(mag_s3[l] >> (pos_s3 - TOP_POS));
			end else begin
				nm_c[l] = MAG_W'(mag_s3[l] << (TOP_POS - pos_s3));
			end
		end
	end

	assign mx01 = (mag_s1[1] > mag_s1[0]) ? mag_s1[1] : mag_s1[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			neg_s1[l] <= in_vec[l][VEC_W-1];
			mag_s1[l] <= in_vec[l][VEC_W-1] ? (VEC_W'(0) - in_vec[l]) : in_vec[l];
		end
		ok_s1   <= in_ok;
		side_s1 <= in_side;

		max_s2  <= (mag_s1[2] > mx01) ? mag_s1[2] : mx01;
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		ok_s2   <= ok_s1 & (mag_s1 != '0);
		side_s2 <= side_s1;

		pos_s3  <= pos_c;
		max_s3  <= max_s2;
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;
		ok_s3   <= ok_s2;
		side_s3 <= side_s2;

		nm_s4   <= nm_c;
		neg_s4  <= neg_s3;
		ok_s4   <= ok_s3 & (max_s3 != '0);
		side_s4 <= side_s3;

		for (int l = 0; l < 3; l++) begin
			sq_s5[l] <= SQ_W'(nm_s4[l]) * SQ_W'(nm_s4[l]);
		end
		nm_s5   <= nm_s4;
		neg_s5  <= neg_s4;
		ok_s5   <= ok_s4;
		side_s5 <= side_s4;

		sum_s6  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
		nm_s6   <= nm_s5;
		neg_s6  <= neg_s5;
		ok_s6   <= ok_s5;
		side_s6 <= side_s5;
	end

	logic                  sq_vld;
	logic [ROOT_W-1:0]     sq_root;
	logic [SQPW-1:0]       sq_pass;
	logic [2:0][MAG_W-1:0] sq_mag;

	lav_sqrt #(
		.PW(SQPW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s6),
		.in_sum   (sum_s6),
		.in_pass  ({side_s6, ok_s6, neg_s6, nm_s6}),
		.out_valid(sq_vld),
		.out_root (sq_root),
		.out_pass (sq_pass)
	);

	assign sq_mag = sq_pass[3*MAG_W-1:0];

	logic                  dv_vld;
	logic [2:0][QW-1:0]    dv_quo;
	logic [DVPW-1:0]       dv_pass;

	lav_div #(
		.FRAC_BITS(FRAC_BITS),
		.PW       (DVPW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_vld),
		.in_den   (sq_root),
		.in_mag   (sq_mag),
		.in_pass  (sq_pass[SQPW-1:3*MAG_W]),
		.out_valid(dv_vld),
		.out_quo  (dv_quo),
		.out_pass (dv_pass)
	);

	logic [2:0][UW-1:0] unit_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= dv_pass[DVPW-1:4];
		ok_s7   <= dv_pass[3];
		for (int l = 0; l < 3; l++) begin
			if (dv_pass[l]) begin
				unit_s7[l] <= UW'(0) - {1'b0, dv_quo[l]};
			end else begin
				unit_s7[l] <= {1'b0, dv_quo[l]};
			end
		end
	end

	assign out_valid = vld_s7;
	assign out_ok    = ok_s7;
	assign out_unit  = unit_s7;
	assign out_side  = side_s7;

endmodule

// ----- hdl/look_at_view_matrix_top.sv -----
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Left-handed look-at view matrix in fixed point, emitted as four columns.
// ----------------------------------------------------------------------------
//  channel   signals             direction  handshake
//  command   start, busy, cmd    in         taken when start & !busy
//  result    strobe, result      out        one column per cycle, no hold-off
//
//  Each item yields four column items, one per cycle, so busy stays
//  high after an accept while the command counter counts down to zero;
//  the single result port sets how often items are taken. The path from
//  the accept to column 0 runs through three normalizers of FRAC_BITS+39
//  stages (six front stages, a 31-stage root, a (FRAC_BITS+1)-stage divider,
//  one output stage) and ten stages around them. Reset clears all valid bits
//  and the column sequencer; nothing ever stalls inside.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lav_pkg::lav_cmd_t cmd,
	output logic              strobe,
	output lav_pkg::lav_res_t result
);
	import lav_pkg::*;

	localparam int UW   = FRAC_BITS + 2;
	localparam int PAW  = UW + WORD_W;
	localparam int PBW  = 2 * UW;
	localparam int EW   = 3 * WORD_W;
	localparam int S1W  = 2 * EW;
	localparam int S2W  = EW + 3 * UW;
	localparam int S3W  = EW + 6 * UW;
	localparam logic [VEC_W-1:0] POS_MAX = VEC_W'(32'h7FFF_FFFF);
	localparam logic [VEC_W-1:0] NEG_MAX = VEC_W'(32'h8000_0000);

	logic [1:0] cnt_q;
	logic       take;

	assign take = start & ~busy;
	assign busy = cnt_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (take) begin
			cnt_q <= 2'd3;
		end else if (busy) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	logic                   vld_s1;
	logic [2:0][VEC_W-1:0]  f_s1;
	logic [2:0][WORD_W-1:0] eye_s1, up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		eye_s1 <= {cmd.eye_z, cmd.eye_y, cmd.eye_x};
		up_s1  <= {cmd.upward_z, cmd.upward_y, cmd.upward_x};
		f_s1[0] <= VEC_W'(33'(cmd.aim_x) - 33'(cmd.eye_x));
		f_s1[1] <= VEC_W'(33'(cmd.aim_y) - 33'(cmd.eye_y));
		f_s1[2] <= VEC_W'(33'(cmd.aim_z) - 33'(cmd.eye_z));
	end

	logic                n1_vld, n1_ok;
	logic [2:0][UW-1:0]  n1_unit;
	logic [S1W-1:0]      n1_side;

	lav_norm #(
		.FRAC_BITS(FRAC_BITS),
		.SW       (S1W)
	) u_norm_f (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_ok    (1'b1),
		.in_vec   (f_s1),
		.in_side  ({eye_s1, up_s1}),
		.out_valid(n1_vld),
		.out_ok   (n1_ok),
		.out_unit (n1_unit),
		.out_side (n1_side)
	);

	logic [2:0][WORD_W-1:0] n1_eye, n1_up;
	assign {n1_eye, n1_up} = n1_side;

	logic                      vld_s2, ok_s2;
	logic signed [PAW-1:0]     pa_s2 [6];
	logic [2:0][UW-1:0]        f_s2;
	logic [2:0][WORD_W-1:0]    eye_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= n1_vld;
		end
	end

	always_ff @(posedge clk) begin
		pa_s2[0] <= $signed(n1_unit[1]) * $signed(n1_up[2]);
		pa_s2[1] <= $signed(n1_unit[2]) * $signed(n1_up[1]);
		pa_s2[2] <= $signed(n1_unit[2]) * $signed(n1_up[0]);
		pa_s2[3] <= $signed(n1_unit[0]) * $signed(n1_up[2]);
		pa_s2[4] <= $signed(n1_unit[0]) * $signed(n1_up[1]);
		pa_s2[5] <= $signed(n1_unit[1]) * $signed(n1_up[0]);
		ok_s2  <= n1_ok;
		f_s2   <= n1_unit;
		eye_s2 <= n1_eye;
	end

	logic                   vld_s3, ok_s3;
	logic [2:0][VEC_W-1:0]  c_s3;
	logic [2:0][UW-1:0]     f_s3;
	logic [2:0][WORD_W-1:0] eye_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		c_s3[0] <= VEC_W'(pa_s2[0]) - VEC_W'(pa_s2[1]);
		c_s3[1] <= VEC_W'(pa_s2[2]) - VEC_W'(pa_s2[3]);
		c_s3[2] <= VEC_W'(pa_s2[4]) - VEC_W'(pa_s2[5]);
		ok_s3  <= ok_s2;
		f_s3   <= f_s2;
		eye_s3 <= eye_s2;
	end

	logic                n2_vld, n2_ok;
	logic [2:0][UW-1:0]  n2_unit;
	logic [S2W-1:0]      n2_side;

	lav_norm #(
		.FRAC_BITS(FRAC_BITS),
		.SW       (S2W)
	) u_norm_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_ok    (ok_s3),
		.in_vec   (c_s3),
		.in_side  ({eye_s3, f_s3}),
		.out_valid(n2_vld),
		.out_ok   (n2_ok),
		.out_unit (n2_unit),
		.out_side (n2_side)
	);

	logic [2:0][WORD_W-1:0] n2_eye;
	logic [2:0][UW-1:0]     n2_f;
	assign {n2_eye, n2_f} = n2_side;

	logic                   vld_s4, ok_s4;
	logic signed [PBW-1:0]  pb_s4 [6];
	logic [2:0][UW-1:0]     f_s4, r_s4;
	logic [2:0][WORD_W-1:0] eye_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= n2_vld;
		end
	end

	always_ff @(posedge clk) begin
		pb_s4[0] <= $signed(n2_unit[1]) * $signed(n2_f[2]);
		pb_s4[1] <= $signed(n2_unit[2]) * $signed(n2_f[1]);
		pb_s4[2] <= $signed(n2_unit[2]) * $signed(n2_f[0]);
		pb_s4[3] <= $signed(n2_unit[0]) * $signed(n2_f[2]);
		pb_s4[4] <= $signed(n2_unit[0]) * $signed(n2_f[1]);
		pb_s4[5] <= $signed(n2_unit[1]) * $signed(n2_f[0]);
		ok_s4  <= n2_ok;
		f_s4   <= n2_f;
		r_s4   <= n2_unit;
		eye_s4 <= n2_eye;
	end

	logic                   vld_s5, ok_s5;
	logic [2:0][VEC_W-1:0]  c_s5;
	logic [2:0][UW-1:0]     f_s5, r_s5;
	logic [2:0][WORD_W-1:0] eye_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		c_s5[0] <= VEC_W'(pb_s4[0]) - VEC_W'(pb_s4[1]);
		c_s5[1] <= VEC_W'(pb_s4[2]) - VEC_W'(pb_s4[3]);
		c_s5[2] <= VEC_W'(pb_s4[4]) - VEC_W'(pb_s4[5]);
		ok_s5  <= ok_s4;
		f_s5   <= f_s4;
		r_s5   <= r_s4;
		eye_s5 <= eye_s4;
	end

	logic                n3_vld, n3_ok;
	logic [2:0][UW-1:0]  n3_unit;
	logic [S3W-1:0]      n3_side;

	lav_norm #(
		.FRAC_BITS(FRAC_BITS),
		.SW       (S3W)
	) u_norm_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s5),
		.in_ok    (ok_s5),
		.in_vec   (c_s5),
		.in_side  ({eye_s5, f_s5, r_s5}),
		.out_valid(n3_vld),
		.out_ok   (n3_ok),
		.out_unit (n3_unit),
		.out_side (n3_side)
	);

	logic [2:0][WORD_W-1:0] n3_eye;
	logic [2:0][UW-1:0]     n3_f, n3_r;
	assign {n3_eye, n3_f, n3_r} = n3_side;

	// axes in row order: r, u, f
	logic [2:0][2:0][UW-1:0] ax_n3;
	assign ax_n3[0] = n3_r;
	assign ax_n3[1] = n3_unit;
	assign ax_n3[2] = n3_f;

	logic                     vld_s6, ok_s6;
	logic signed [PAW-1:0]    pd_s6 [3][3];
	logic [2:0][2:0][UW-1:0]  ax_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= n3_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			for (int e = 0; e < 3; e++) begin
				pd_s6[a][e] <= $signed(ax_n3[a][e]) * $signed(n3_eye[e]);
			end
		end
		ok_s6 <= n3_ok;
		ax_s6 <= ax_n3;
	end

	logic                     vld_s7, ok_s7;
	logic [2:0][VEC_W-1:0]    ng_s7;
	logic [2:0][2:0][UW-1:0]  ax_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			ng_s7[a] <= VEC_W'(0) - (VEC_W'(pd_s6[a][0]) + VEC_W'(pd_s6[a][1])
				+ VEC_W'(pd_s6[a][2]));
		end
		ok_s7 <= ok_s6;
		ax_s7 <= ax_s6;
	end

	logic                     vld_s8, ok_s8;
	logic [2:0][VEC_W-1:0]    sh_s8;
	logic [2:0]               neg_s8;
	logic [2:0][2:0][UW-1:0]  ax_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			neg_s8[a] <= ng_s7[a][VEC_W-1];
			if (ng_s7[a][VEC_W-1]) begin
				sh_s8[a] <= (VEC_W'(0) - ng_s7[a]) >> FRAC_BITS;
			end else begin
				sh_s8[a] <= ng_s7[a] >> FRAC_BITS;
			end
		end
		ok_s8 <= ok_s7;
		ax_s8 <= ax_s7;
	end

	logic                     vld_s9, ok_s9;
	logic [2:0][WORD_W-1:0]   dot_s9;
	logic [2:0][2:0][UW-1:0]  ax_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (neg_s8[a]) begin
				if (sh_s8[a] > NEG_MAX) begin
					dot_s9[a] <= NEG_MAX[WORD_W-1:0];
				end else begin
					dot_s9[a] <= WORD_W'(0) - sh_s8[a][WORD_W-1:0];
				end
			end else begin
				if (sh_s8[a] > POS_MAX) begin
					dot_s9[a] <= POS_MAX[WORD_W-1:0];
				end else begin
					dot_s9[a] <= sh_s8[a][WORD_W-1:0];
				end
			end
		end
		ok_s9 <= ok_s8;
		ax_s9 <= ax_s8;
	end

	// column sequencer
	logic                     act_q;
	logic [COL_W-1:0]         idx_q;
	logic                     ok_q;
	logic [2:0][WORD_W-1:0]   dot_q;
	logic [2:0][2:0][UW-1:0]  ax_q;
	logic                     strobe_q;
	lav_res_t                 res_q;

	function automatic lav_res_t make_col(
		input logic [COL_W-1:0]        k,
		input logic                    ok,
		input logic [2:0][WORD_W-1:0]  d,
		input logic [2:0][2:0][UW-1:0] ax
	);
		lav_res_t c;
		c.column_index = k;
		c.degenerate   = ~ok;
		c.last_column  = k == LAST_COL;
		if (!ok) begin
			c.elem0 = '0;
			c.elem1 = '0;
			c.elem2 = '0;
			c.elem3 = '0;
		end else if (k == LAST_COL) begin
			c.elem0 = d[0];
			c.elem1 = d[1];
			c.elem2 = d[2];
			c.elem3 = WORD_W'(1) << FRAC_BITS;
		end else begin
			c.elem0 = WORD_W'($signed(ax[0][k]));
			c.elem1 = WORD_W'($signed(ax[1][k]));
			c.elem2 = WORD_W'($signed(ax[2][k]));
			c.elem3 = '0;
		end
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			idx_q    <= FIRST_COL;
			strobe_q <= 1'b0;
		end else if (vld_s9) begin
			act_q    <= 1'b1;
			idx_q    <= FIRST_COL + 2'd1;
			strobe_q <= 1'b1;
		end else if (act_q) begin
			idx_q    <= idx_q + 2'd1;
			strobe_q <= 1'b1;
			if (idx_q == LAST_COL) act_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s9) begin
			ok_q  <= ok_s9;
			dot_q <= dot_s9;
			ax_q  <= ax_s9;
			res_q <= make_col(FIRST_COL, ok_s9, dot_s9, ax_s9);
		end else if (act_q) begin
			res_q <= make_col(idx_q, ok_q, dot_q, ax_q);
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule
